// ----- rtl/core/spr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CNT_W       = 5;
    localparam int TOT_W       = CNT_W + 2;
    localparam int Q_DEPTH     = 4;
    localparam int QA_W        = $clog2(Q_DEPTH);
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;

    localparam logic [2:0] REG_PATTERN_LOW      = 3'd0;
    localparam logic [2:0] REG_PATTERN_HIGH     = 3'd1;
    localparam logic [2:0] REG_PATTERN_LEN      = 3'd2;
    localparam logic [2:0] REG_REPLACEMENT_LOW  = 3'd3;
    localparam logic [2:0] REG_REPLACEMENT_HIGH = 3'd4;
    localparam logic [2:0] REG_REPLACEMENT_LEN  = 3'd5;
    localparam logic [2:0] REG_BINARY_MODE      = 3'd6;

    typedef logic [MAX_PATTERN-1:0][7:0] t_bytes;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       stream_last;
        logic       config_error;
    } t_out_beat;

    typedef struct packed {
        t_bytes           pattern;
        logic [CNT_W-1:0] pattern_len;
        t_bytes           replacement;
        logic [CNT_W-1:0] replacement_len;
        logic             binary_mode;
        logic             err;
        logic [CNT_W-1:0] shrink;
    } t_cfg;

    // one entry per input beat that produces output: literal bytes, then
    // replacement bytes, then zero bytes; all counts zero means a bare end marker
    typedef struct packed {
        t_bytes           lit;
        logic [CNT_W-1:0] lit_cnt;
        logic [CNT_W-1:0] rep_cnt;
        logic [CNT_W-1:0] zero_cnt;
        logic             eos;
        logic             err;
    } t_job;

endpackage

`default_nettype wire

// ----- rtl/core/spr_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spr_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [spr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [spr_pkg::DATA_W-1:0] pwdata,
    output logic      [spr_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output spr_pkg::t_cfg                  o_cfg,
    output logic                           o_cfg_wr
);
    import spr_pkg::*;

    t_bytes           r_pattern;
    t_bytes           r_replacement;
    logic [CNT_W-1:0] r_plen;
    logic [CNT_W-1:0] r_rlen;
    logic             r_bin;
    logic [2:0]       reg_idx;
    logic             wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern     <= '0;
            r_replacement <= '0;
            r_plen        <= '0;
            r_rlen        <= '0;
            r_bin         <= 1'b0;
        end else if (wr) begin
            case (reg_idx)
                REG_PATTERN_LOW:      r_pattern[7:0]       <= pwdata;
                REG_PATTERN_HIGH:     r_pattern[15:8]      <= pwdata;
                REG_PATTERN_LEN:      r_plen               <= pwdata[CNT_W-1:0];
                REG_REPLACEMENT_LOW:  r_replacement[7:0]   <= pwdata;
                REG_REPLACEMENT_HIGH: r_replacement[15:8]  <= pwdata;
                REG_REPLACEMENT_LEN:  r_rlen               <= pwdata[CNT_W-1:0];
                REG_BINARY_MODE:      r_bin                <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // writes to an unmapped slot leave the datapath alone
    assign o_cfg_wr = wr && (reg_idx <= REG_BINARY_MODE);

    always_comb begin
        case (reg_idx)
            REG_PATTERN_LOW:      prdata = r_pattern[7:0];
            REG_PATTERN_HIGH:     prdata = r_pattern[15:8];
            REG_PATTERN_LEN:      prdata = DATA_W'(r_plen);
            REG_REPLACEMENT_LOW:  prdata = r_replacement[7:0];
            REG_REPLACEMENT_HIGH: prdata = r_replacement[15:8];
            REG_REPLACEMENT_LEN:  prdata = DATA_W'(r_rlen);
            REG_BINARY_MODE:      prdata = DATA_W'(r_bin);
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.pattern         = r_pattern;
        o_cfg.pattern_len     = r_plen;
        o_cfg.replacement     = r_replacement;
        o_cfg.replacement_len = r_rlen;
        o_cfg.binary_mode     = r_bin;
        o_cfg.err             = (r_plen == '0) || (r_plen > CNT_W'(MAX_PATTERN))
                                || (r_rlen > CNT_W'(MAX_PATTERN))
                                || (r_bin && (r_rlen > r_plen));
        o_cfg.shrink          = (r_bin && !o_cfg.err) ? (r_plen - r_rlen) : '0;
    end

endmodule

`default_nettype wire

// ----- rtl/core/spr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spr_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  spr_pkg::t_cfg          i_cfg,
    input  wire logic              i_cfg_wr,
    input  wire logic              i_in_valid,
    input  spr_pkg::t_in_beat      i_in,
    output logic                   o_in_ready,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output spr_pkg::t_job          o_job
);
    import spr_pkg::*;

    t_bytes           r_win;
    logic [CNT_W-1:0] r_fill;
    logic             r_tail;

    t_bytes           nw;
    t_bytes           n_win;
    logic [CNT_W-1:0] n_fill;
    logic             n_tail;
    logic [CNT_W-1:0] fill_sel;
    logic [CNT_W-1:0] fill_inc;
    logic [IDX_W-1:0] wr_idx;
    logic [MAX_PATTERN-1:0] eq;
    logic             hit;
    logic             accept;
    logic             eos;
    logic [7:0]       b;

    assign b          = i_in.in_byte;
    assign eos        = i_in.end_of_stream;
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && (eos || (o_job.lit_cnt != '0) || (o_job.rep_cnt != '0)
                                   || (o_job.zero_cnt != '0));

    always_comb begin
        if (i_cfg.err) begin
            fill_sel = r_fill;
        end else if (r_fill >= i_cfg.pattern_len) begin
            fill_sel = '0;
        end else begin
            fill_sel = r_fill;
        end
        fill_inc = fill_sel + CNT_W'(1);
        wr_idx   = fill_sel[IDX_W-1:0];

        for (int k = 0; k < MAX_PATTERN; k++) begin
            nw[k] = (IDX_W'(k) == wr_idx) ? b : r_win[k];
            eq[k] = (nw[k] == i_cfg.pattern[k]) || (CNT_W'(k) >= i_cfg.pattern_len);
        end
        hit = &eq;

        for (int k = 0; k < MAX_PATTERN - 1; k++) begin
            n_win[k] = nw[k+1];
        end
        n_win[MAX_PATTERN-1] = nw[MAX_PATTERN-1];

        o_job.lit      = nw;
        o_job.lit_cnt  = '0;
        o_job.rep_cnt  = '0;
        o_job.zero_cnt = '0;
        o_job.eos      = eos;
        o_job.err      = i_cfg.err;
        n_fill         = r_fill;
        n_tail         = r_tail;

        if (i_cfg.err) begin
            o_job.lit_cnt = fill_inc;
            n_fill        = '0;
            n_tail        = 1'b0;
        end else if (r_tail) begin
            o_job.lit[0] = b;
            if (b == 8'd0) begin
                o_job.zero_cnt = i_cfg.shrink + CNT_W'(1);
                n_tail         = 1'b0;
            end else begin
                o_job.lit_cnt = CNT_W'(1);
                if (eos) begin
                    o_job.zero_cnt = i_cfg.shrink;
                end
            end
        end else if (fill_inc == i_cfg.pattern_len) begin
            if (hit) begin
                o_job.rep_cnt = i_cfg.replacement_len;
                n_fill        = '0;
                if (i_cfg.binary_mode) begin
                    if (eos) begin
                        o_job.zero_cnt = i_cfg.shrink;
                    end else begin
                        n_tail = 1'b1;
                    end
                end
            end else begin
                // oldest byte leaves; at the end the rest of the window follows
                o_job.lit_cnt = eos ? i_cfg.pattern_len : CNT_W'(1);
                n_fill        = i_cfg.pattern_len - CNT_W'(1);
            end
        end else begin
            n_fill = fill_inc;
            if (eos) begin
                o_job.lit_cnt = fill_inc;
            end
        end

        if (eos) begin
            n_fill = '0;
            n_tail = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_tail <= 1'b0;
        end else if (i_cfg_wr) begin
            r_fill <= '0;
            r_tail <= 1'b0;
        end else if (accept) begin
            r_fill <= n_fill;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= (fill_inc == i_cfg.pattern_len && !hit) ? n_win : nw;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/spr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spr_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  spr_pkg::t_job i_job,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_valid,
    output spr_pkg::t_job o_head
);
    import spr_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QA_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QA_W+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QA_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QA_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QA_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QA_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/spr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spr_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  spr_pkg::t_cfg     i_cfg,
    input  wire logic         i_valid,
    input  spr_pkg::t_job     i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output spr_pkg::t_out_beat o_out
);
    import spr_pkg::*;

    logic [TOT_W-1:0] r_pos;
    logic             r_valid;
    t_out_beat        r_out;

    logic [TOT_W-1:0] total;
    logic [TOT_W-1:0] lit_end;
    logic [TOT_W-1:0] rep_end;
    logic [TOT_W-1:0] rep_off;
    logic             advance;
    logic             last;
    t_out_beat        beat;

    assign o_out_valid = r_valid;
    assign o_out       = r_out;
    assign advance     = i_valid && (!r_valid || i_out_ready);
    assign o_pop       = advance && last;

    always_comb begin
        lit_end = TOT_W'(i_head.lit_cnt);
        rep_end = lit_end + TOT_W'(i_head.rep_cnt);
        total   = rep_end + TOT_W'(i_head.zero_cnt);
        rep_off = r_pos - lit_end;
        last    = (total == '0) || (r_pos == total - TOT_W'(1));

        if (r_pos < lit_end) begin
            beat.out_byte = i_head.lit[r_pos[IDX_W-1:0]];
        end else if (r_pos < rep_end) begin
            beat.out_byte = i_cfg.replacement[rep_off[IDX_W-1:0]];
        end else begin
            beat.out_byte = 8'd0;
        end
        beat.has_byte     = (total != '0);
        beat.run_last     = last;
        beat.stream_last  = last && i_head.eos;
        beat.config_error = i_head.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else if (advance) begin
            r_pos   <= last ? '0 : r_pos + TOT_W'(1);
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= beat;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/stream_pattern_replacer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streaming find-and-replace on a byte stream. The front end takes one input
// beat per clock unless the queue is full, shifts it into a 16-byte match
// window and compares the whole window with the pattern combinationally; each
// beat that produces output is queued as one job (held bytes, replacement,
// zero padding) in a 4-entry queue. The back end emits one output beat per
// clock from the queue head unless the output stalls; a job gives up to 17
// beats, a bare end marker counting as one. Input throughput is one beat per
// clock while the average output per input stays at one beat or less. Output
// is registered, so results appear in the cycle after they are formed.
// Registers sit at byte address 8*i on a 64-bit APB-style port; the user must
// write them only while the stream is idle, which the block does not enforce.
module stream_pattern_replacer (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  spr_pkg::t_in_beat              i_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output spr_pkg::t_out_beat             o_out,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [spr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [spr_pkg::DATA_W-1:0] pwdata,
    output logic      [spr_pkg::DATA_W-1:0] prdata,
    output logic                           pready
);
    import spr_pkg::*;

    t_cfg cfg;
    logic cfg_wr;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    t_job job;
    t_job head;

    spr_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_cfg_wr (cfg_wr)
    );

    spr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cfg_wr   (cfg_wr),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_ready (o_in_ready),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (job)
    );

    spr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    spr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (q_valid),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
